[design/hse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants for the heap sort engine
// Item layouts, command codes and the memory request bundle that the sort
// sequencer hands to the top level.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 10;
    localparam int COUNT_W      = 11;
    // Widest store address over the supported capacity range
    localparam int ADDR_MAX_W   = 20;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic                     error;
    } out_item_t;

    // One read and one write request to the element store per cycle
    typedef struct packed {
        logic                     rd_en;
        logic [ADDR_MAX_W-1:0]    rd_addr;
        logic                     wr_en;
        logic [ADDR_MAX_W-1:0]    wr_addr;
        logic signed [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

[design/heap_sort_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heap_sort_engine: element store with in-place ascending heap sort
// Loads, reads and clears work on one synchronous store; a sort command
// runs the heap sort sequencer over the loaded elements.
// ----------------------------------------------------------------------------
// Each command returns one item. Load, clear and any rejected command write
// their result straight into the output register; a read that hits passes
// the registered store read and then the T_RD_RSP state. A sort holds off
// new items while the sequencer walks the store through its single read and
// single write port. A result item waits in an output register; the next
// item is taken at once when no result is pending, otherwise only in the
// cycle in which the pending result is accepted.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hse_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hse_pkg::out_item_t     out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > hse_pkg::IDX_W) ? CW : hse_pkg::IDX_W;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SORT,
        T_SORT_RSP,
        T_RD_RSP
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              out_valid_reg, out_valid_next;
    hse_pkg::out_item_t                out_item_reg, out_item_next;

    logic signed [hse_pkg::DATA_W-1:0] store_mem [CAPACITY];
    logic signed [hse_pkg::DATA_W-1:0] mem_rd_data_reg;
    logic                              mem_rd_en, mem_wr_en;
    logic [AW-1:0]                     mem_rd_addr, mem_wr_addr;
    logic signed [hse_pkg::DATA_W-1:0] mem_wr_data;

    hse_pkg::mem_req_t                 sreq;
    logic                              sort_busy, sort_done, sort_start;

    logic                              accept, out_free, full, rd_ok;
    logic [LW-1:0]                     idx_l, cnt_l;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == T_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign idx_l     = LW'(in_item.index);
    assign cnt_l     = LW'(count_reg);
    assign rd_ok     = idx_l < cnt_l;
    assign sort_start = accept && (in_item.cmd == hse_pkg::CMD_SORT);

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Sort sequencer
    hse_sort_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_start),
        .n       (count_reg),
        .rd_data (mem_rd_data_reg),
        .req     (sreq),
        .busy    (sort_busy),
        .done    (sort_done)
    );

    // Store port arbitration: sequencer owns the store while sorting
    always_comb
    begin
        if (sort_busy)
        begin
            mem_rd_en   = sreq.rd_en;
            mem_rd_addr = sreq.rd_addr[AW-1:0];
            mem_wr_en   = sreq.wr_en;
            mem_wr_addr = sreq.wr_addr[AW-1:0];
            mem_wr_data = sreq.wr_data;
        end
        else
        begin
            mem_rd_en   = accept && (in_item.cmd == hse_pkg::CMD_READ) && rd_ok;
            mem_rd_addr = idx_l[AW-1:0];
            mem_wr_en   = accept && (in_item.cmd == hse_pkg::CMD_LOAD) && !full;
            mem_wr_addr = count_reg[AW-1:0];
            mem_wr_data = in_item.value;
        end
    end

    // Element store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            store_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            mem_rd_data_reg <= store_mem[mem_rd_addr];
    end

    // Command handling and result register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    out_item_next.data  = '0;
                    out_item_next.error = 1'b0;
                    unique case (in_item.cmd)
                        hse_pkg::CMD_LOAD:
                        begin
                            if (full)
                                out_item_next.error = 1'b1;
                            else
                                count_next = count_reg + CW'(1);
                            out_valid_next = 1'b1;
                        end
                        hse_pkg::CMD_SORT:
                        begin
                            state_next = T_SORT;
                        end
                        hse_pkg::CMD_READ:
                        begin
                            if (rd_ok)
                            begin
                                state_next = T_RD_RSP;
                            end
                            else
                            begin
                                out_item_next.error = 1'b1;
                                out_valid_next      = 1'b1;
                            end
                        end
                        hse_pkg::CMD_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = T_IDLE;
                        end
                    endcase
                    out_item_next.count = hse_pkg::COUNT_W'(count_next);
                end
            end
            T_SORT:
            begin
                if (sort_done)
                    state_next = T_SORT_RSP;
            end
            T_SORT_RSP:
            begin
                if (out_free)
                begin
                    out_item_next.data  = '0;
                    out_item_next.count = hse_pkg::COUNT_W'(count_reg);
                    out_item_next.error = 1'b0;
                    out_valid_next      = 1'b1;
                    state_next          = T_IDLE;
                end
            end
            T_RD_RSP:
            begin
                if (out_free)
                begin
                    out_item_next.data  = mem_rd_data_reg;
                    out_item_next.count = hse_pkg::COUNT_W'(count_reg);
                    out_item_next.error = 1'b0;
                    out_valid_next      = 1'b1;
                    state_next          = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_accept_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        sort_busy |-> !in_ready)
        else $error("item accepted while sort in progress");

    a_full_load_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_item.cmd == hse_pkg::CMD_LOAD) && full)
        |=> (out_valid_reg && out_item_reg.error && $stable(count_reg)))
        else $error("load into full store not flagged");

    a_sort_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        sort_busy |=> $stable(count_reg))
        else $error("count changed during sort");

endmodule
`default_nettype wire

[design/hse_sort_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_sort_ctrl: in-place heap sort sequencer
// Builds a max-heap, then moves the root to the end of a shrinking heap.
// Sift-down carries the moving value in a register and writes each level
// once, so no step needs more than one read or one write on the element store.
// ----------------------------------------------------------------------------
module hse_sort_ctrl #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [$clog2(CAPACITY+1)-1:0]    n,
    input  wire logic signed [hse_pkg::DATA_W-1:0] rd_data,
    output hse_pkg::mem_req_t                     req,
    output logic                                  busy,
    output logic                                  done
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLD_RD,
        S_BLD_V,
        S_CHILD_L,
        S_CHILD_R,
        S_CMP,
        S_NEXT,
        S_EX_R0,
        S_EX_RK,
        S_EX_W,
        S_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic                             build_reg, build_next;
    logic [CW-1:0]                    n_reg, n_next;
    logic [CW-1:0]                    k_reg, k_next;
    logic [CW-1:0]                    size_reg, size_next;
    logic [AW-1:0]                    node_reg, node_next;
    logic signed [hse_pkg::DATA_W-1:0] v_reg, v_next;
    logic signed [hse_pkg::DATA_W-1:0] lval_reg, lval_next;
    logic                             right_ok_reg, right_ok_next;

    logic [AW+1:0]                    lc_w, rc_w, size_w;
    logic                             has_l, has_r;
    logic [CW-1:0]                    k_dec;
    logic signed [hse_pkg::DATA_W-1:0] best;
    logic [AW-1:0]                    best_idx;
    logic                             moved;

    // Child positions of the current node, two bits wider than a node index
    assign lc_w   = {1'b0, node_reg, 1'b1};
    assign rc_w   = lc_w + (AW+2)'(1);
    assign size_w = (AW+2)'(size_reg);
    assign has_l  = lc_w < size_w;
    assign has_r  = rc_w < size_w;
    assign k_dec  = k_reg - CW'(1);

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // Pick the largest of node value, left child and right child
    always_comb
    begin
        best     = v_reg;
        best_idx = node_reg;
        moved    = 1'b0;
        if (lval_reg > v_reg)
        begin
            best     = lval_reg;
            best_idx = lc_w[AW-1:0];
            moved    = 1'b1;
        end
        if (right_ok_reg && (rd_data > best))
        begin
            best     = rd_data;
            best_idx = rc_w[AW-1:0];
            moved    = 1'b1;
        end
    end

    // Sequencer next state and store requests
    always_comb
    begin
        state_next    = state_reg;
        build_next    = build_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        size_next     = size_reg;
        node_next     = node_reg;
        v_next        = v_reg;
        lval_next     = lval_reg;
        right_ok_next = right_ok_reg;
        req           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next    = n;
                    size_next = n;
                    k_next    = n >> 1;
                    build_next = 1'b1;
                    if (n < CW'(2))
                        state_next = S_DONE;
                    else
                        state_next = S_BLD_RD;
                end
            end
            S_BLD_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = hse_pkg::ADDR_MAX_W'(k_dec[AW-1:0]);
                node_next   = k_dec[AW-1:0];
                state_next  = S_BLD_V;
            end
            S_BLD_V:
            begin
                v_next     = rd_data;
                state_next = S_CHILD_L;
            end
            S_CHILD_L:
            begin
                if (has_l)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = hse_pkg::ADDR_MAX_W'(lc_w[AW-1:0]);
                    state_next  = S_CHILD_R;
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = hse_pkg::ADDR_MAX_W'(node_reg);
                    req.wr_data = v_reg;
                    state_next  = S_NEXT;
                end
            end
            S_CHILD_R:
            begin
                lval_next     = rd_data;
                right_ok_next = has_r;
                if (has_r)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = hse_pkg::ADDR_MAX_W'(rc_w[AW-1:0]);
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = hse_pkg::ADDR_MAX_W'(node_reg);
                req.wr_data = best;
                if (moved)
                begin
                    node_next  = best_idx;
                    state_next = S_CHILD_L;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (build_reg)
                begin
                    if (k_reg == CW'(1))
                    begin
                        build_next = 1'b0;
                        k_next     = n_reg - CW'(1);
                        state_next = S_EX_R0;
                    end
                    else
                    begin
                        k_next     = k_dec;
                        state_next = S_BLD_RD;
                    end
                end
                else
                begin
                    if (k_reg == CW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_dec;
                        state_next = S_EX_R0;
                    end
                end
            end
            S_EX_R0:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                state_next  = S_EX_RK;
            end
            S_EX_RK:
            begin
                lval_next   = rd_data;
                req.rd_en   = 1'b1;
                req.rd_addr = hse_pkg::ADDR_MAX_W'(k_reg[AW-1:0]);
                state_next  = S_EX_W;
            end
            S_EX_W:
            begin
                // old root goes to the end, last element sifts from the root
                v_next      = rd_data;
                req.wr_en   = 1'b1;
                req.wr_addr = hse_pkg::ADDR_MAX_W'(k_reg[AW-1:0]);
                req.wr_data = lval_reg;
                node_next   = '0;
                size_next   = k_reg;
                state_next  = S_CHILD_L;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Loop counters and carried values
    always_ff @(posedge clk)
    begin
        build_reg    <= build_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        size_reg     <= size_next;
        node_reg     <= node_next;
        v_reg        <= v_next;
        lval_reg     <= lval_next;
        right_ok_reg <= right_ok_next;
    end

endmodule
`default_nettype wire

[verif/heap_sort_engine_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heap_sort_engine_test: self-checking bench for the heap sort engine
// Items are queued by a stimulus block and driven over valid/ready. A shadow
// copy of the element store predicts every result item, and the monitor
// compares each returned item field by field. Stimulus is a short directed
// run, one sequence that fills the store to capacity, then random
// clear/load/sort/read sequences under three idling profiles.
// ----------------------------------------------------------------------------
module heap_sort_engine_test;

    localparam int CAP        = hse_pkg::CAPACITY_DEF;
    localparam int HALF_CLK   = 10;
    localparam int PHASE_ITEMS = 25;
    localparam int PRINT_MAX  = 50;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    hse_pkg::in_item_t  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    hse_pkg::out_item_t out_item;

    // Stimulus and scoreboard storage
    hse_pkg::in_item_t  pending_items[$];
    hse_pkg::out_item_t expected_results[$];
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    int        items_queued = 0;
    int        result_num = 0;
    int        fail_count = 0;

    // Shadow copy of the engine's element store
    logic signed [hse_pkg::DATA_W-1:0] held_elems [CAP];
    logic [hse_pkg::COUNT_W-1:0]       held_count = '0;

    heap_sort_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Clock and reset
    initial
    begin
        forever #HALF_CLK clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sift one node down a max-heap of the given size
    function automatic void sift_held(int heap_size, int node);
        int top;
        int lc;
        logic signed [hse_pkg::DATA_W-1:0] t;
        forever
        begin
            top = node;
            lc = 2 * node + 1;
            if (lc < heap_size && held_elems[lc] > held_elems[top])
                top = lc;
            if (lc + 1 < heap_size && held_elems[lc + 1] > held_elems[top])
                top = lc + 1;
            if (top == node)
                return;
            t = held_elems[node];
            held_elems[node] = held_elems[top];
            held_elems[top] = t;
            node = top;
        end
    endfunction

    // Ascending in-place heap sort of the held elements
    function automatic void heap_sort_held();
        int n;
        logic signed [hse_pkg::DATA_W-1:0] t;
        n = held_count;
        if (n < 2)
            return;
        for (int k = n / 2 - 1; k >= 0; k--)
            sift_held(n, k);
        for (int k = n - 1; k > 0; k--)
        begin
            t = held_elems[0];
            held_elems[0] = held_elems[k];
            held_elems[k] = t;
            sift_held(k, 0);
        end
    endfunction

    // Apply one command to the shadow store and return the result item
    function automatic hse_pkg::out_item_t predict_result(hse_pkg::in_item_t it);
        hse_pkg::out_item_t r;
        r = '0;
        case (it.cmd)
            hse_pkg::CMD_LOAD:
            begin
                if (held_count < CAP)
                begin
                    held_elems[held_count[hse_pkg::IDX_W-1:0]] = it.value;
                    held_count = held_count + 1'b1;
                end
                else
                    r.error = 1'b1;
            end
            hse_pkg::CMD_SORT:
                heap_sort_held();
            hse_pkg::CMD_READ:
            begin
                if (it.index < held_count)
                    r.data = held_elems[it.index];
                else
                    r.error = 1'b1;
            end
            default:
                held_count = '0;
        endcase
        r.count = held_count;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [hse_pkg::DATA_W-1:0] got,
                                   logic [hse_pkg::DATA_W-1:0] want);
        if (fail_count < PRINT_MAX)
            $display("MISMATCH result %0d %s: got %0h, expected %0h",
                     result_num, field, got, want);
        fail_count++;
    endtask

    // Driver: present queued items, idling at random between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_result(in_item));
            if (in_valid && !in_ready)
                ;
            else if (pending_items.size() != 0 &&
                     $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                in_item  <= pending_items.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check returned items and throttle out_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected item", out_item.data, '0);
                else
                begin
                    hse_pkg::out_item_t want;
                    want = expected_results.pop_front();
                    if (out_item.data !== want.data)
                        report_mismatch("data", out_item.data, want.data);
                    if (out_item.count !== want.count)
                        report_mismatch("count", out_item.count, want.count);
                    if (out_item.error !== want.error)
                        report_mismatch("error", out_item.error, want.error);
                end
                result_num++;
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    task automatic push_cmd(hse_pkg::cmd_t c, logic signed [hse_pkg::DATA_W-1:0] v,
                            logic [hse_pkg::IDX_W-1:0] idx);
        hse_pkg::in_item_t it;
        it.cmd   = c;
        it.value = v;
        it.index = idx;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Element values biased toward extremes and duplicates
    function automatic logic signed [hse_pkg::DATA_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3, 4: return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Clear, load, optionally sort, read back, and a little noise at the end
    task automatic push_sequence(int n_loads, int extra_loads);
        int held;
        int n_reads;
        int idx;
        push_cmd(hse_pkg::CMD_CLEAR, $urandom, $urandom_range(0, CAP - 1));
        held = 0;
        for (int i = 0; i < n_loads + extra_loads; i++)
        begin
            push_cmd(hse_pkg::CMD_LOAD, rand_element(), $urandom_range(0, CAP - 1));
            if (held < CAP)
                held++;
        end
        if ($urandom_range(0, 99) < 85)
            push_cmd(hse_pkg::CMD_SORT, $urandom, $urandom_range(0, CAP - 1));
        n_reads = $urandom_range(1, (held < 30) ? held + 2 : 32);
        for (int i = 0; i < n_reads; i++)
        begin
            if (held > 0 && (held == CAP || $urandom_range(0, 99) < 85))
                idx = $urandom_range(0, held - 1);
            else
                idx = $urandom_range(held, CAP - 1);
            push_cmd(hse_pkg::CMD_READ, $urandom, hse_pkg::IDX_W'(idx));
        end
        if (held == CAP)
            push_cmd(hse_pkg::CMD_READ, $urandom, hse_pkg::IDX_W'(CAP - 1));
        // Grow the loaded set by one and sort again
        if (held < CAP && $urandom_range(0, 99) < 30)
        begin
            push_cmd(hse_pkg::CMD_LOAD, rand_element(), $urandom_range(0, CAP - 1));
            push_cmd(hse_pkg::CMD_SORT, $urandom, $urandom_range(0, CAP - 1));
            push_cmd(hse_pkg::CMD_READ, $urandom, $urandom_range(0, held));
            push_cmd(hse_pkg::CMD_READ, $urandom, hse_pkg::IDX_W'(held));
        end
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 4))
                push_cmd(hse_pkg::cmd_t'($urandom_range(0, 3)), $urandom,
                         $urandom_range(0, CAP - 1));
    endtask

    task automatic run_random_phase(int s_pct, int r_pct);
        int first;
        int pick;
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        first = items_queued;
        while (items_queued - first < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                push_sequence($urandom_range(0, 12), 0);
            else if (pick < 95)
                push_sequence($urandom_range(13, 64), 0);
            else
                push_sequence($urandom_range(65, 200), 0);
        end
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        sender_idle_pct   = 12;
        receiver_idle_pct = 75;

        // Empty store: read miss, sort and clear of nothing
        push_cmd(hse_pkg::CMD_READ, 32'sd0, 10'd0);
        push_cmd(hse_pkg::CMD_SORT, 32'sd0, 10'd0);
        push_cmd(hse_pkg::CMD_CLEAR, 32'sd0, 10'd0);
        // Sort of a single element
        push_cmd(hse_pkg::CMD_LOAD, 32'sh7FFF_FFFF, 10'd0);
        push_cmd(hse_pkg::CMD_SORT, 32'sd0, 10'd0);
        push_cmd(hse_pkg::CMD_READ, 32'sd0, 10'd0);
        // Extremes, zero and a duplicate
        push_cmd(hse_pkg::CMD_LOAD, 32'sh8000_0000, 10'h3FF);
        push_cmd(hse_pkg::CMD_LOAD, 32'sd0, 10'd0);
        push_cmd(hse_pkg::CMD_LOAD, -32'sd1, 10'd0);
        push_cmd(hse_pkg::CMD_LOAD, 32'sd1, 10'd0);
        push_cmd(hse_pkg::CMD_LOAD, -32'sd1, 10'd0);
        push_cmd(hse_pkg::CMD_SORT, -32'sd1, 10'h3FF);
        for (int i = 0; i < 6; i++)
            push_cmd(hse_pkg::CMD_READ, 32'sd0, hse_pkg::IDX_W'(i));
        // Index at count and index all ones
        push_cmd(hse_pkg::CMD_READ, 32'sd0, 10'd6);
        push_cmd(hse_pkg::CMD_READ, 32'sd0, 10'h3FF);
        push_cmd(hse_pkg::CMD_CLEAR, -32'sd1, 10'h3FF);
        push_cmd(hse_pkg::CMD_READ, 32'sd0, 10'd0);
        push_cmd(hse_pkg::CMD_LOAD, 32'sd1, 10'd0);
        push_cmd(hse_pkg::CMD_READ, 32'sd0, 10'd0);

        // Fill to capacity, overflow loads, full sort unless the random draw skips it
        push_sequence(CAP, 3);

        run_random_phase(12, 75);
        run_random_phase(75, 12);
        run_random_phase(0, 0);

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("missing items", expected_results.size(), '0);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
